/* design/poly_eval_with_derivative_unit_defines.svh */
// ----------------------------------------------------------------------------
// poly_eval_with_derivative_unit_defines.svh
// Assertion macros used by the checker file pewd_chk.sv.
// ----------------------------------------------------------------------------
`ifndef POLY_EVAL_WITH_DERIVATIVE_UNIT_DEFINES_SVH
`define POLY_EVAL_WITH_DERIVATIVE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while i_rst_n is low.
`define PEWD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while i_rst_n is low.
`define PEWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pewd_pkg.sv */
// ----------------------------------------------------------------------------
// pewd_pkg
// Types, sizes and saturation helper for the polynomial/derivative unit.
// ----------------------------------------------------------------------------
package pewd_pkg;

    localparam int NUM_COEFFS  = 8;                 // 2 .. 8
    localparam int MAX_COEFFS  = 8;                 // register file depth
    localparam int NUM_CELLS   = NUM_COEFFS - 1;
    localparam int CIDX_W      = $clog2(MAX_COEFFS);
    localparam int COEFF_W     = 32;
    localparam int X_W         = 32;
    localparam int ACC_W       = 48;
    localparam int FRAC_W      = 16;
    localparam int HI_W        = ACC_W - FRAC_W;    // upper slice of a running value
    localparam int PP_HI_W     = HI_W + X_W;
    localparam int PP_LO_W     = FRAC_W + 1 + X_W;
    localparam int SUM_W       = 64;

    localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef logic [CIDX_W-1:0] t_cidx;

    // Running values handed from cell to cell
    typedef struct packed {
        logic signed [ACC_W-1:0] p;
        logic signed [ACC_W-1:0] d;
        logic signed [X_W-1:0]   x;
        logic                    sat;
    } t_horner;

    typedef struct packed {
        logic [ACC_W-1:0] poly;
        logic [ACC_W-1:0] deriv;
        logic             sat;
    } t_result;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             flag;
    } t_sat;

    function automatic t_sat sat48(input logic [SUM_W-1:0] v);
        t_sat r;
        if (v[SUM_W-1:ACC_W-1] != {(SUM_W-ACC_W+1){v[SUM_W-1]}}) begin
            r.flag  = 1'b1;
            r.value = v[SUM_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            r.flag  = 1'b0;
            r.value = v[ACC_W-1:0];
        end
        return r;
    endfunction

endpackage

/* design/pewd_in_if.sv */
// ----------------------------------------------------------------------------
// pewd_in_if
// Input channel: one evaluation point per transfer.
// ----------------------------------------------------------------------------
interface pewd_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pewd_pkg::X_W-1:0]    x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

/* design/pewd_out_if.sv */
// ----------------------------------------------------------------------------
// pewd_out_if
// Output channel: p(x), p'(x) and the saturation flag per transfer.
// ----------------------------------------------------------------------------
interface pewd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [pewd_pkg::ACC_W-1:0]  poly_value;
    logic signed [pewd_pkg::ACC_W-1:0]  deriv_value;
    logic                               saturated;

    modport source (output valid, output poly_value, output deriv_value,
                    output saturated, input ready);
    modport sink   (input valid, input poly_value, input deriv_value,
                    input saturated, output ready);
endinterface

/* design/pewd_cell.sv */
// ----------------------------------------------------------------------------
// pewd_cell
// One Horner step for p and d: split products, then add, shift and saturate.
// ----------------------------------------------------------------------------
module pewd_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  pewd_pkg::t_horner                   i_data,
    input  logic signed [pewd_pkg::COEFF_W-1:0] i_coeff,
    output logic                                o_valid,
    output pewd_pkg::t_horner                   o_data
);
    import pewd_pkg::*;

    // stage A: partial products
    logic                       r_valid_a;
    logic signed [PP_HI_W-1:0]  r_hi_p, r_hi_d;
    logic signed [PP_LO_W-1:0]  r_lo_p, r_lo_d;
    logic signed [ACC_W-1:0]    r_p_add;
    logic signed [X_W-1:0]      r_x_a;
    logic                       r_sat_a;

    logic signed [HI_W-1:0]     a_hi_p, a_hi_d;
    logic signed [FRAC_W:0]     a_lo_p, a_lo_d;

    // stage B: combine
    logic                       r_valid_b;
    t_horner                    r_out;
    logic [SUM_W-1:0]           sum_p, sum_d;
    t_sat                       sat_p, sat_d;

    // a = hi * 2^16 + lo with lo unsigned, so floor(a*x/2^16) = hi*x + (lo*x >>> 16)
    assign a_hi_p = i_data.p[ACC_W-1:FRAC_W];
    assign a_hi_d = i_data.d[ACC_W-1:FRAC_W];
    assign a_lo_p = {1'b0, i_data.p[FRAC_W-1:0]};
    assign a_lo_d = {1'b0, i_data.d[FRAC_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_hi_p  <= PP_HI_W'(a_hi_p) * PP_HI_W'($signed(i_data.x));
            r_hi_d  <= PP_HI_W'(a_hi_d) * PP_HI_W'($signed(i_data.x));
            r_lo_p  <= PP_LO_W'(a_lo_p) * PP_LO_W'($signed(i_data.x));
            r_lo_d  <= PP_LO_W'(a_lo_d) * PP_LO_W'($signed(i_data.x));
            r_p_add <= i_data.p;
            r_x_a   <= i_data.x;
            r_sat_a <= i_data.sat;
        end
    end

    always_comb begin
        sum_p = SUM_W'(r_hi_p)
              + {{(SUM_W-PP_LO_W+FRAC_W){r_lo_p[PP_LO_W-1]}}, r_lo_p[PP_LO_W-1:FRAC_W]}
              + {{(SUM_W-COEFF_W){i_coeff[COEFF_W-1]}}, i_coeff};
        sum_d = SUM_W'(r_hi_d)
              + {{(SUM_W-PP_LO_W+FRAC_W){r_lo_d[PP_LO_W-1]}}, r_lo_d[PP_LO_W-1:FRAC_W]}
              + {{(SUM_W-ACC_W){r_p_add[ACC_W-1]}}, r_p_add};
        sat_p = sat48(sum_p);
        sat_d = sat48(sum_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
        end else if (i_en) begin
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_valid_a) begin
            r_out.p   <= sat_p.value;
            r_out.d   <= sat_d.value;
            r_out.x   <= r_x_a;
            r_out.sat <= r_sat_a | sat_p.flag | sat_d.flag;
        end
    end

    assign o_valid = r_valid_b;
    assign o_data  = r_out;

endmodule

/* design/pewd_out_buf.sv */
// ----------------------------------------------------------------------------
// pewd_out_buf
// Output register with one skid entry; the chain stalls only when it fills.
// ----------------------------------------------------------------------------
module pewd_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pewd_pkg::t_result   i_data,
    output logic                o_ready,
    pewd_out_if.source          o_out
);
    import pewd_pkg::*;

    logic       r_out_valid, n_out_valid;
    logic       r_skid_valid, n_skid_valid;
    t_result    r_out_data, r_skid_data;
    logic       pop, push, load_out, load_skid, skid_to_out;

    assign o_ready     = !r_skid_valid;
    assign pop         = r_out_valid && o_out.ready;
    assign push        = i_valid && o_ready;
    assign skid_to_out = pop && r_skid_valid;
    assign load_out    = push && (!r_out_valid || pop);
    assign load_skid   = push && r_out_valid && !pop;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (skid_to_out) begin
            n_skid_valid = 1'b0;
        end else if (load_out) begin
            n_out_valid = 1'b1;
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
        if (load_skid) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (skid_to_out) begin
            r_out_data <= r_skid_data;
        end else if (load_out) begin
            r_out_data <= i_data;
        end
        if (load_skid) begin
            r_skid_data <= i_data;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.poly_value  = r_out_data.poly;
    assign o_out.deriv_value = r_out_data.deriv;
    assign o_out.saturated   = r_out_data.sat;

endmodule

/* design/poly_eval_with_derivative_unit.sv */
// ----------------------------------------------------------------------------
// poly_eval_with_derivative_unit
// Streams degree-7 fixed-point p(x) and p'(x), one point per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one Q16.16 point per clock and returns p(x) and p'(x) in Q32.16 with a
// saturation flag, in input order. The Horner scheme runs as a chain of
// NUM_COEFFS-1 cells, each one step for both values; a cell splits its 48x32
// products into two registered partial products and then adds, shifts and
// saturates in a second register stage. From input transfer to result valid
// a point passes the two stages of each cell and then the output register.
// Sustained throughput is one point per cycle while the output side takes
// results; a one-entry skid behind the output register lets the chain keep
// moving when the output first stalls, and input ready drops only once that
// entry is full. The user must write coefficients through the configuration
// write port only while no point is in flight; the block does not enforce it.
module poly_eval_with_derivative_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  pewd_pkg::t_cidx                     i_cfg_index,
    input  logic [pewd_pkg::COEFF_W-1:0]        i_cfg_wdata,
    pewd_in_if.sink                             i_in,
    pewd_out_if.source                          o_out
);
    import pewd_pkg::*;

    logic signed [COEFF_W-1:0]  r_coeff [MAX_COEFFS];
    logic                       en;
    logic                       chain_valid [NUM_CELLS+1];
    t_horner                    chain_data  [NUM_CELLS+1];
    t_result                    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_COEFFS; i++) begin
                r_coeff[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_coeff[i_cfg_index] <= i_cfg_wdata;
        end
    end

    assign i_in.ready = en;

    // Horner start: p = top coefficient, d = 0
    assign chain_valid[0]    = i_in.valid;
    assign chain_data[0].p   = {{(ACC_W-COEFF_W){r_coeff[NUM_COEFFS-1][COEFF_W-1]}},
                                r_coeff[NUM_COEFFS-1]};
    assign chain_data[0].d   = '0;
    assign chain_data[0].x   = i_in.x_value;
    assign chain_data[0].sat = 1'b0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        pewd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .i_coeff (r_coeff[NUM_COEFFS-2-g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    assign res.poly  = chain_data[NUM_CELLS].p;
    assign res.deriv = chain_data[NUM_CELLS].d;
    assign res.sat   = chain_data[NUM_CELLS].sat;

    pewd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[NUM_CELLS] && en),
        .i_data  (res),
        .o_ready (en),
        .o_out   (o_out)
    );

endmodule

/* design/pewd_chk.sv */
// ----------------------------------------------------------------------------
// pewd_chk
// Port-level checks on the output buffering and input backpressure.
// ----------------------------------------------------------------------------
`include "poly_eval_with_derivative_unit_defines.svh"

module pewd_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [pewd_pkg::ACC_W-1:0]          out_poly,
    input  logic [pewd_pkg::ACC_W-1:0]          out_deriv,
    input  logic                                out_sat
);
    // a stalled result holds until its transfer
    `PEWD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_poly) && $stable(out_deriv) && $stable(out_sat), "stalled result changed")

    // the skid entry only fills behind a full output register
    `PEWD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

    `PEWD_ASSERT_NOW(a_stall_needs_result, !in_ready, out_valid, "input stalled without pending result")

    // backpressure comes only from a refused result
    `PEWD_ASSERT_NOW(a_ready_fall_cause, $fell(in_ready), $past(out_valid && !out_ready), "ready fell without output stall")

    `PEWD_ASSERT_NOW(a_reset_clears_out, $past(!i_rst_n), !out_valid, "result valid straight after reset")

endmodule

bind poly_eval_with_derivative_unit pewd_chk u_pewd_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_poly  (o_out.poly_value),
    .out_deriv (o_out.deriv_value),
    .out_sat   (o_out.saturated)
);
